/* sv/cdst_pkg.sv */
// shared types, constants and time-increment functions for the clock display controller
package cdst_pkg;

	localparam int TICKS_PER_UPDATE = 100;
	localparam int SCAN_SLOTS = 8;
	localparam int MAX_BRIGHTNESS = 4;

	typedef enum logic [1:0] {
		ACT_SCAN = 2'd0,
		ACT_TIME = 2'd1,
		ACT_KEY  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FLD_SEC  = 2'd0,
		FLD_MIN  = 2'd1,
		FLD_HOUR = 2'd2
	} rtc_field_t;

	localparam int KEY_HOUR = 0;
	localparam int KEY_MIN = 1;
	localparam int KEY_SEC = 2;
	localparam int KEY_BRIGHT = 3;

	localparam logic [7:0] TUBE_CODE [8] = '{
		8'h20, 8'h40, 8'h80, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] keys_pressed;
		logic [6:0] sec_bcd;
		logic [6:0] min_bcd;
		logic [5:0] hour_bcd;
	} item_t;

	typedef struct packed {
		logic       display_valid;
		logic [7:0] display_byte;
		logic       colon_lit;
		logic       time_request;
		logic       rtc_write;
		logic [1:0] rtc_field;
		logic [6:0] rtc_data;
	} result_t;

	typedef struct packed {
		logic [2:0]      brightness;
		logic            colon;
		logic [3:0][3:0] digits;
	} disp_t;

	function automatic logic [6:0] next_minute(input logic [6:0] m);
		logic [7:0] v;
		v = {1'b0, m} + 8'd1;
		if (v[3:0] >= 4'd10) begin
			v = (v & 8'h70) + 8'h10;
		end
		if ((v & 8'h70) >= 8'h60) begin
			v = 8'h00;
		end
		return v[6:0];
	endfunction

	function automatic logic [5:0] next_hour(input logic [5:0] h);
		logic [7:0] v;
		v = {2'b0, h} + 8'd1;
		if (v[3:0] >= 4'd10) begin
			v = (v & 8'h30) + 8'h10;
		end
		if ((v & 8'h30) == 8'h20 && v[3:0] == 4'd4) begin
			v = 8'h00;
		end
		return v[5:0];
	endfunction

endpackage

/* sv/cdst_ctrl.sv */
// time sample and key handling: digits, colon, brightness and rtc write requests
module cdst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cdst_pkg::item_t    item,
	output cdst_pkg::disp_t    disp,
	output logic               rtc_write,
	output logic [1:0]         rtc_field,
	output logic [6:0]         rtc_data
);

	logic [2:0]      brightness_q;
	logic            colon_q;
	logic [6:0]      prev_sec_q;
	logic [3:0][3:0] digits_q;
	logic            key_held_q;

	logic [2:0]      bright_inc;
	logic            new_press;
	logic            is_key;

	assign is_key = item.action == cdst_pkg::ACT_KEY;
	assign new_press = is_key && item.keys_pressed != 4'd0 && !key_held_q;
	assign bright_inc = (brightness_q >= 3'(cdst_pkg::MAX_BRIGHTNESS)) ? 3'd0
		: brightness_q + 3'd1;

	always_comb begin
		rtc_write = 1'b0;
		rtc_field = cdst_pkg::FLD_SEC;
		rtc_data = 7'd0;
		if (new_press && !item.keys_pressed[cdst_pkg::KEY_BRIGHT]) begin
			rtc_write = 1'b1;
			if (item.keys_pressed[cdst_pkg::KEY_SEC]) begin
				rtc_field = cdst_pkg::FLD_SEC;
			end else if (item.keys_pressed[cdst_pkg::KEY_MIN]) begin
				rtc_field = cdst_pkg::FLD_MIN;
				rtc_data = cdst_pkg::next_minute(item.min_bcd);
			end else begin
				rtc_field = cdst_pkg::FLD_HOUR;
				rtc_data = {1'b0, cdst_pkg::next_hour(item.hour_bcd)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 3'(cdst_pkg::MAX_BRIGHTNESS);
			colon_q <= 1'b0;
			prev_sec_q <= 7'd0;
			digits_q <= '0;
			key_held_q <= 1'b0;
		end else if (en) begin
			case (item.action)
				cdst_pkg::ACT_TIME: begin
					if (prev_sec_q != item.sec_bcd) begin
						colon_q <= ~colon_q;
					end
					prev_sec_q <= item.sec_bcd;
					digits_q[0] <= {2'b0, item.hour_bcd[5:4]};
					digits_q[1] <= item.hour_bcd[3:0];
					digits_q[2] <= {1'b0, item.min_bcd[6:4]};
					digits_q[3] <= item.min_bcd[3:0];
				end
				cdst_pkg::ACT_KEY: begin
					key_held_q <= item.keys_pressed != 4'd0;
					if (new_press) begin
						if (item.keys_pressed[cdst_pkg::KEY_BRIGHT]) begin
							brightness_q <= bright_inc;
						end else if (item.keys_pressed[cdst_pkg::KEY_SEC]) begin
							colon_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign disp.brightness = brightness_q;
	assign disp.colon = colon_q;
	assign disp.digits = digits_q;

endmodule

/* sv/cdst_scan.sv */
// scan slot sequencer and time request tick counter
module cdst_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            is_scan,
	input  cdst_pkg::disp_t disp,
	output logic [7:0]      display_byte,
	output logic            colon_lit,
	output logic            time_request
);

	logic [2:0] slot_q;
	logic [6:0] tick_q;
	logic [6:0] tick_inc;
	logic [3:0] digit;
	logic       slot_wrap;

	assign digit = slot_q[2] ? disp.digits[0] : disp.digits[slot_q[1:0]];
	assign display_byte = is_scan ? (cdst_pkg::TUBE_CODE[slot_q] | {4'b0, digit}) : 8'd0;
	assign colon_lit = is_scan && disp.colon && slot_q < 3'd2;
	assign slot_wrap = ({2'b0, slot_q} + 5'd1 + {2'b0, disp.brightness})
		>= 5'(cdst_pkg::SCAN_SLOTS);
	assign tick_inc = tick_q + 7'd1;
	assign time_request = is_scan && tick_inc >= 7'(cdst_pkg::TICKS_PER_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 3'd0;
			tick_q <= 7'd0;
		end else if (en && is_scan) begin
			slot_q <= slot_wrap ? 3'd0 : slot_q + 3'd1;
			tick_q <= time_request ? 7'd0 : tick_inc;
		end
	end

endmodule

/* sv/clock_display_scan_and_time_set.sv */
// Four-tube multiplexed clock controller: each transfer in gives exactly one result transfer.
// An item is registered on input, processed once the result register is free or being
// read, and held in the result register; one item per cycle is sustained while out_ready
// stays high. The input register and the result register decouple the two channels, so
// one new item can still be taken while a finished result waits for out_ready.
module clock_display_scan_and_time_set (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [3:0] keys_pressed,
	input  logic [6:0] sec_bcd,
	input  logic [6:0] min_bcd,
	input  logic [5:0] hour_bcd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       display_valid,
	output logic [7:0] display_byte,
	output logic       colon_lit,
	output logic       time_request,
	output logic       rtc_write,
	output logic [1:0] rtc_field,
	output logic [6:0] rtc_data
);

	cdst_pkg::item_t   item_s1;
	logic              valid_s1;
	cdst_pkg::result_t result_s2;
	logic              valid_s2;
	cdst_pkg::result_t result_d;
	cdst_pkg::disp_t   disp;
	logic              advance;
	logic              is_scan;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign is_scan = item_s1.action == cdst_pkg::ACT_SCAN;

	cdst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (item_s1),
		.disp      (disp),
		.rtc_write (result_d.rtc_write),
		.rtc_field (result_d.rtc_field),
		.rtc_data  (result_d.rtc_data)
	);

	cdst_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.is_scan      (is_scan),
		.disp         (disp),
		.display_byte (result_d.display_byte),
		.colon_lit    (result_d.colon_lit),
		.time_request (result_d.time_request)
	);

	assign result_d.display_valid = is_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action <= action;
			item_s1.keys_pressed <= keys_pressed;
			item_s1.sec_bcd <= sec_bcd;
			item_s1.min_bcd <= min_bcd;
			item_s1.hour_bcd <= hour_bcd;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid = valid_s2;
	assign display_valid = result_s2.display_valid;
	assign display_byte = result_s2.display_byte;
	assign colon_lit = result_s2.colon_lit;
	assign time_request = result_s2.time_request;
	assign rtc_write = result_s2.rtc_write;
	assign rtc_field = result_s2.rtc_field;
	assign rtc_data = result_s2.rtc_data;

`ifndef NO_ASSERTIONS
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are stalled");
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed item did not reach the result register");
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && display_valid) |-> !rtc_write)
		else $error("scan result also requests an rtc write");
	a_req_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !display_valid) |-> (!time_request && !colon_lit && display_byte == 8'd0))
		else $error("display fields driven outside a scan tick");
	a_tube_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(display_byte[7:4]))
		else $error("more than one tube selected");
`endif

endmodule
